// ===== hdl/slpg_pkg.sv =====
`default_nettype none

package slpg_pkg;

   // Operation codes
   localparam logic OP_SET    = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // Mode codes
   localparam logic [3:0] MODE_BOOT     = 4'd0;
   localparam logic [3:0] MODE_RECOVERY = 4'd1;
   localparam logic [3:0] MODE_UPDATE   = 4'd2;
   localparam logic [3:0] MODE_WAIT     = 4'd3;
   localparam logic [3:0] MODE_VERIFY   = 4'd4;
   localparam logic [3:0] MODE_COMMIT   = 4'd5;
   localparam logic [3:0] MODE_READY    = 4'd6;
   localparam logic [3:0] MODE_ERASE    = 4'd7;
   localparam logic [3:0] MODE_FAULT    = 4'd8;
   localparam logic [3:0] MODE_RUNNING  = 4'd9;
   localparam logic [3:0] MODE_TRIAL    = 4'd10;
   localparam logic [3:0] MODE_PROBE    = 4'd11;

   localparam logic [7:0] SLOT_NONE = 8'd255;
   localparam logic [7:0] SLOT_ONE  = 8'd1;
   localparam logic [7:0] SLOT_APPS = 8'd2;

   localparam logic [3:0] ERROR_MIN        = 4'd1;
   localparam logic [3:0] ERROR_MAX        = 4'd9;
   localparam logic [3:0] ERROR_CODE_RESET = 4'd9;

   // Pattern timing in milliseconds
   localparam int unsigned HALF_ON_MS      = 500;
   localparam int unsigned RECOVERY_ON_MS  = 1000;
   localparam int unsigned WAIT_ON_MS      = 150;
   localparam int unsigned VERIFY_ON_MS    = 800;
   localparam int unsigned PULSE_PERIOD_MS = 300;
   localparam int unsigned PULSE_WIDTH_MS  = 150;
   localparam int unsigned FRAME_MS        = 4000;
   localparam int unsigned PULSE_SLOTS     = (FRAME_MS + PULSE_PERIOD_MS - 1) / PULSE_PERIOD_MS;
   localparam int unsigned INTRO_LENGTH_MS = 4000;
   localparam int unsigned INTRO_DARK_MS   = 3000;
   localparam int unsigned INTRO_STEP_MS   = 1000;
   localparam int unsigned INTRO_LIT_MS    = 800;

   localparam logic [3:0] PULSES_READY = 4'd4;
   localparam logic [3:0] PULSES_PROBE = 4'd1;
   localparam logic [3:0] PULSES_NONE  = 4'd3;

   typedef struct packed {
      logic red;
      logic green;
      logic blue;
   } rgb_type;

   localparam rgb_type RGB_OFF   = '{red: 1'b0, green: 1'b0, blue: 1'b0};
   localparam rgb_type RGB_RED   = '{red: 1'b1, green: 1'b0, blue: 1'b0};
   localparam rgb_type RGB_GREEN = '{red: 1'b0, green: 1'b1, blue: 1'b0};
   localparam rgb_type RGB_BLUE  = '{red: 1'b0, green: 1'b0, blue: 1'b1};

   typedef enum logic [3:0] {
      PAT_BOOT,
      PAT_RECOVERY,
      PAT_UPDATE,
      PAT_WAIT,
      PAT_VERIFY,
      PAT_COMMIT,
      PAT_ERASE,
      PAT_PULSE,
      PAT_INTRO
   } pattern_type;

   // Accepted request word
   typedef struct packed {
      logic        operation;
      logic [3:0]  mode_code;
      logic [7:0]  slot;
      logic [3:0]  error_code;
      logic [31:0] time_ms;
   } req_word_type;

   // Sample word after state lookup
   typedef struct packed {
      pattern_type pattern;
      logic [31:0] elapsed;
      logic [11:0] intro_time;
      logic        intro_row;
      logic [3:0]  pulse_count;
      rgb_type     pulse_rgb;
   } sample_word_type;

   // Sample word after the first residue fold
   typedef struct packed {
      pattern_type pattern;
      logic [15:0] fold_4000;
      logic [15:0] fold_2000;
      logic [15:0] fold_1000;
      logic [4:0]  low_bits;
      rgb_type     intro_rgb;
      logic [3:0]  pulse_count;
      rgb_type     pulse_rgb;
   } fold_word_type;

   // Sample word with final phases
   typedef struct packed {
      pattern_type pattern;
      logic [11:0] phase_4000;
      logic [10:0] phase_2000;
      logic [9:0]  phase_1000;
      rgb_type     intro_rgb;
      logic [3:0]  pulse_count;
      rgb_type     pulse_rgb;
   } phase_word_type;

   function automatic logic is_app_mode(input logic [3:0] mode);
      return (mode == MODE_RUNNING) || (mode == MODE_TRIAL) || (mode == MODE_PROBE);
   endfunction

endpackage

`default_nettype wire

// ===== hdl/slpg_if.sv =====
`default_nettype none

interface slpg_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [3:0]  mode_code;
   logic [7:0]  slot;
   logic [3:0]  error_code;
   logic [31:0] time_ms;

   modport source (output valid, output operation, output mode_code, output slot,
                   output error_code, output time_ms, input ready);
   modport sink   (input valid, input operation, input mode_code, input slot,
                   input error_code, input time_ms, output ready);
endinterface

interface slpg_rsp_if;
   logic valid;
   logic ready;
   logic red_on;
   logic green_on;
   logic blue_on;

   modport source (output valid, output red_on, output green_on, output blue_on,
                   input ready);
   modport sink   (input valid, input red_on, input green_on, input blue_on,
                   output ready);
endinterface

`default_nettype wire

// ===== hdl/status_led_pattern_generator.sv =====
// RGB status LED pattern generator.
// req_chan carries timestamped words. A set word (operation 0) checks a
// mode, slot and error code and updates the stored mode; it gives no
// result. A sample word (operation 1) gives one rsp_chan word with the
// red, green and blue on-bits for the stored mode at time_ms.
// csr_write_data is the fault code used for bad set words; write it while
// the block is idle. Reset value 9.
// A sample word reaches rsp_chan through the input register, state
// lookup, residue fold, phase reduction and colour registers in turn.
// A set word takes effect as it leaves the input register, so every
// later sample sees it. One word is accepted per cycle while rsp_chan
// keeps taking results, set or sample in any mix.
// When rsp_chan stalls, words gather in the stage registers and the
// output register; req_chan.ready drops only once all of them are full.
// Reset (synchronous) empties the pipeline, returns to boot mode with no
// slot and no intro, and sets the fault code back to 9.
`default_nettype none

module status_led_pattern_generator (
   input  wire logic       clock,
   input  wire logic       reset,
   slpg_req_if.sink        req_chan,
   slpg_rsp_if.source      rsp_chan,
   input  wire logic       csr_write_enable,
   input  wire logic [3:0] csr_write_data
);
   import slpg_pkg::*;

   sample_word_type sample_word;
   logic            sample_valid, sample_ready;
   phase_word_type  phase_word;
   logic            phase_valid, phase_ready;

   slpg_state u_state (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .down_word        (sample_word),
      .down_valid       (sample_valid),
      .down_ready       (sample_ready)
   );

   slpg_phase u_phase (
      .clock      (clock),
      .reset      (reset),
      .up_word    (sample_word),
      .up_valid   (sample_valid),
      .up_ready   (sample_ready),
      .down_word  (phase_word),
      .down_valid (phase_valid),
      .down_ready (phase_ready)
   );

   slpg_colour u_colour (
      .clock    (clock),
      .reset    (reset),
      .up_word  (phase_word),
      .up_valid (phase_valid),
      .up_ready (phase_ready),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== hdl/slpg_state.sv =====
`default_nettype none

module slpg_state (
   input  wire logic                     clock,
   input  wire logic                     reset,
   slpg_req_if.sink                      req_chan,
   input  wire logic                     csr_write_enable,
   input  wire logic [3:0]               csr_write_data,
   output slpg_pkg::sample_word_type     down_word,
   output logic                          down_valid,
   input  wire logic                     down_ready
);
   import slpg_pkg::*;

   logic            s1_valid_ff, s1_valid_in;
   req_word_type    s1_word_ff;
   logic            s2_valid_ff, s2_valid_in;
   sample_word_type s2_word_ff, s2_word_in;

   logic [3:0]  code_ff;
   logic [3:0]  cur_mode_ff, cur_mode_in;
   logic [7:0]  cur_slot_ff, cur_slot_in;
   logic [3:0]  cur_error_ff, cur_error_in;
   logic [31:0] since_ff, since_in;
   logic [31:0] intro_start_ff, intro_start_in;
   logic [7:0]  intro_slot_ff, intro_slot_in;
   logic        intro_run_ff, intro_run_in;
   logic        intro_done_ff, intro_done_in;

   logic s2_open, s1_leave, s1_ready, is_set;

   logic       slot_ok, err_ok, req_ok, set_changed, new_app, intro_start_now;
   logic [3:0] new_mode, new_error;
   logic [7:0] new_slot, intro_slot_next;

   logic [31:0] elapsed, intro_full;
   logic        slot_legal, intro_hit, intro_fresh, intro_clear;

   // Handshake: a set word leaves the input register at once, a sample waits for room
   assign s2_open        = !s2_valid_ff || down_ready;
   assign is_set         = s1_word_ff.operation == OP_SET;
   assign s1_leave       = s1_valid_ff && (is_set || s2_open);
   assign s1_ready       = !s1_valid_ff || s1_leave;
   assign req_chan.ready = s1_ready;
   assign s1_valid_in    = s1_ready ? req_chan.valid : s1_valid_ff;

   // Capture the request word
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_chan.valid) begin
         s1_word_ff.operation  <= req_chan.operation;
         s1_word_ff.mode_code  <= req_chan.mode_code;
         s1_word_ff.slot       <= req_chan.slot;
         s1_word_ff.error_code <= req_chan.error_code;
         s1_word_ff.time_ms    <= req_chan.time_ms;
      end
   end

   // Check a set request and substitute fault for a bad one
   always_comb begin
      slot_ok = (s1_word_ff.slot < SLOT_APPS) || (s1_word_ff.slot == SLOT_NONE);
      if (s1_word_ff.mode_code == MODE_FAULT) begin
         err_ok = (s1_word_ff.error_code >= ERROR_MIN) && (s1_word_ff.error_code <= ERROR_MAX);
      end else begin
         err_ok = s1_word_ff.error_code == 4'd0;
      end
      req_ok = (s1_word_ff.mode_code <= MODE_PROBE) && slot_ok && err_ok &&
               ((s1_word_ff.mode_code != MODE_PROBE) || (s1_word_ff.slot == SLOT_NONE));
      if (req_ok) begin
         new_mode  = s1_word_ff.mode_code;
         new_slot  = s1_word_ff.slot;
         new_error = s1_word_ff.error_code;
      end else begin
         new_mode  = MODE_FAULT;
         new_slot  = SLOT_NONE;
         new_error = code_ff;
      end
      set_changed = (new_mode != cur_mode_ff) || (new_slot != cur_slot_ff) ||
                    (new_error != cur_error_ff);
      new_app         = is_app_mode(new_mode);
      intro_start_now = new_app && ((new_slot < SLOT_APPS) || (new_mode == MODE_PROBE)) &&
                        !intro_done_ff;
      intro_slot_next = intro_start_now ? new_slot : intro_slot_ff;
   end

   // Look up the pattern for a sample
   assign elapsed     = s1_word_ff.time_ms - since_ff;
   assign intro_full  = s1_word_ff.time_ms - intro_start_ff;
   assign slot_legal  = (cur_slot_ff < SLOT_APPS) || (cur_slot_ff == SLOT_NONE);
   assign intro_hit   = intro_run_ff && (cur_slot_ff == intro_slot_ff) &&
                        ((cur_slot_ff < SLOT_APPS) || (cur_mode_ff == MODE_PROBE));
   assign intro_fresh = intro_full < 32'(INTRO_LENGTH_MS);

   always_comb begin
      s2_word_in.pattern     = PAT_PULSE;
      s2_word_in.elapsed     = elapsed;
      s2_word_in.intro_time  = intro_full[11:0];
      s2_word_in.intro_row   = cur_slot_ff == SLOT_ONE;
      s2_word_in.pulse_count = code_ff;
      s2_word_in.pulse_rgb   = RGB_RED;
      intro_clear            = 1'b0;
      unique case (cur_mode_ff)
         MODE_BOOT:     s2_word_in.pattern = PAT_BOOT;
         MODE_RECOVERY: s2_word_in.pattern = PAT_RECOVERY;
         MODE_UPDATE:   s2_word_in.pattern = PAT_UPDATE;
         MODE_WAIT:     s2_word_in.pattern = PAT_WAIT;
         MODE_VERIFY:   s2_word_in.pattern = PAT_VERIFY;
         MODE_COMMIT:   s2_word_in.pattern = PAT_COMMIT;
         MODE_ERASE:    s2_word_in.pattern = PAT_ERASE;
         MODE_READY: begin
            s2_word_in.pulse_count = PULSES_READY;
            s2_word_in.pulse_rgb   = RGB_GREEN;
         end
         MODE_FAULT: begin
            if ((cur_error_ff >= ERROR_MIN) && (cur_error_ff <= ERROR_MAX)) begin
               s2_word_in.pulse_count = cur_error_ff;
            end
         end
         MODE_RUNNING, MODE_TRIAL, MODE_PROBE: begin
            if (slot_legal) begin
               if (intro_hit && intro_fresh) begin
                  s2_word_in.pattern = PAT_INTRO;
               end else begin
                  intro_clear = intro_hit;
                  if (cur_mode_ff == MODE_PROBE) begin
                     s2_word_in.pulse_count = PULSES_PROBE;
                  end else if (cur_slot_ff < SLOT_APPS) begin
                     s2_word_in.pulse_count = cur_slot_ff[3:0] + 4'd1;
                  end else begin
                     s2_word_in.pulse_count = PULSES_NONE;
                  end
                  s2_word_in.pulse_rgb = (cur_mode_ff == MODE_TRIAL) ? RGB_GREEN : RGB_BLUE;
               end
            end
         end
         default: ;
      endcase
   end

   // Advance the mode state
   always_comb begin
      cur_mode_in    = cur_mode_ff;
      cur_slot_in    = cur_slot_ff;
      cur_error_in   = cur_error_ff;
      since_in       = since_ff;
      intro_start_in = intro_start_ff;
      intro_slot_in  = intro_slot_ff;
      intro_run_in   = intro_run_ff;
      intro_done_in  = intro_done_ff;
      if (s1_leave && is_set && set_changed) begin
         since_in     = s1_word_ff.time_ms;
         cur_mode_in  = new_mode;
         cur_slot_in  = new_slot;
         cur_error_in = new_error;
         if (intro_start_now) begin
            intro_start_in = s1_word_ff.time_ms;
            intro_slot_in  = new_slot;
            intro_run_in   = 1'b1;
            intro_done_in  = 1'b1;
         end
         if (!new_app || (new_slot != intro_slot_next)) begin
            intro_run_in = 1'b0;
         end
      end else if (s1_leave && !is_set && intro_clear) begin
         intro_run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff        <= ERROR_CODE_RESET;
         cur_mode_ff    <= MODE_BOOT;
         cur_slot_ff    <= SLOT_NONE;
         cur_error_ff   <= 4'd0;
         since_ff       <= 32'd0;
         intro_start_ff <= 32'd0;
         intro_slot_ff  <= SLOT_NONE;
         intro_run_ff   <= 1'b0;
         intro_done_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            code_ff <= csr_write_data;
         end
         cur_mode_ff    <= cur_mode_in;
         cur_slot_ff    <= cur_slot_in;
         cur_error_ff   <= cur_error_in;
         since_ff       <= since_in;
         intro_start_ff <= intro_start_in;
         intro_slot_ff  <= intro_slot_in;
         intro_run_ff   <= intro_run_in;
         intro_done_ff  <= intro_done_in;
      end
   end

   // Hand the sample word on; set words drop here
   assign s2_valid_in = s2_open ? (s1_valid_ff && !is_set) : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_open) begin
         s2_word_ff <= s2_word_in;
      end
   end

   assign down_valid = s2_valid_ff;
   assign down_word  = s2_word_ff;

   a_intro_needs_done: assert property (@(posedge clock) disable iff (reset)
      intro_run_ff |-> intro_done_ff)
      else $error("intro running without having been started");

   a_error_only_fault: assert property (@(posedge clock) disable iff (reset)
      (cur_mode_ff != MODE_FAULT) |-> (cur_error_ff == 4'd0))
      else $error("error code stored outside fault mode");

   a_change_stamps_time: assert property (@(posedge clock) disable iff (reset)
      (s1_leave && is_set && set_changed) |=> (since_ff == $past(s1_word_ff.time_ms)))
      else $error("mode change did not record its time");

   a_set_gives_no_word: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && is_set && s2_open) |=> !s2_valid_ff)
      else $error("set word passed on as a sample");

endmodule

`default_nettype wire

// ===== hdl/slpg_phase.sv =====
`default_nettype none

module slpg_phase (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire slpg_pkg::sample_word_type up_word,
   input  wire logic                     up_valid,
   output logic                          up_ready,
   output slpg_pkg::phase_word_type      down_word,
   output logic                          down_valid,
   input  wire logic                     down_ready
);
   import slpg_pkg::*;

   // Byte weights modulo 125: 2^8, 2^16, 2^24
   localparam logic [15:0] W1 = 16'd6;
   localparam logic [15:0] W2 = 16'd36;
   localparam logic [15:0] W3 = 16'd91;
   localparam int unsigned RES_BASE = 125;
   localparam int unsigned RES_STEPS = 8;

   logic           s3_valid_ff, s3_valid_in, s3_open;
   fold_word_type  s3_word_ff, s3_word_in;
   logic           s4_valid_ff, s4_valid_in, s4_open;
   phase_word_type s4_word_ff, s4_word_in;

   logic [11:0] intro_t;
   logic [11:0] intro_part;
   logic        intro_lit;
   logic [6:0]  res_4000, res_2000, res_1000;

   // First fold: weighted byte sum, same residue modulo 125
   function automatic logic [15:0] fold_bytes(input logic [31:0] x);
      return 16'(x[31:24]) * W3 + 16'(x[23:16]) * W2 + 16'(x[15:8]) * W1 + 16'(x[7:0]);
   endfunction

   // Second fold and final reduction below 125
   function automatic logic [6:0] reduce_res(input logic [15:0] r);
      logic [10:0] s;
      logic [3:0]  q;
      logic [10:0] d;
      s = 11'(r[15:8]) * 11'(W1) + 11'(r[7:0]);
      q = 4'd0;
      for (int k = 1; k <= RES_STEPS; k++) begin
         if (s >= 11'(k * RES_BASE)) begin
            q = q + 4'd1;
         end
      end
      d = s - 11'(q) * 11'(RES_BASE);
      return d[6:0];
   endfunction

   assign s4_open  = !s4_valid_ff || down_ready;
   assign s3_open  = !s3_valid_ff || s4_open;
   assign up_ready = s3_open;

   // Intro colour for the current second
   always_comb begin
      intro_t    = up_word.intro_time;
      intro_part = 12'd0;
      intro_lit  = 1'b0;
      s3_word_in.intro_rgb = RGB_OFF;
      if (intro_t >= 12'(INTRO_DARK_MS)) begin
         s3_word_in.intro_rgb = RGB_OFF;
      end else if (intro_t >= 12'(2 * INTRO_STEP_MS)) begin
         intro_part = intro_t - 12'(2 * INTRO_STEP_MS);
         intro_lit  = intro_part < 12'(INTRO_LIT_MS);
         s3_word_in.intro_rgb = intro_lit ? (up_word.intro_row ? RGB_GREEN : RGB_BLUE) : RGB_OFF;
      end else if (intro_t >= 12'(INTRO_STEP_MS)) begin
         intro_part = intro_t - 12'(INTRO_STEP_MS);
         intro_lit  = intro_part < 12'(INTRO_LIT_MS);
         s3_word_in.intro_rgb = intro_lit ? (up_word.intro_row ? RGB_BLUE : RGB_GREEN) : RGB_OFF;
      end else begin
         intro_part = intro_t;
         intro_lit  = intro_part < 12'(INTRO_LIT_MS);
         s3_word_in.intro_rgb = intro_lit ? RGB_RED : RGB_OFF;
      end
      s3_word_in.pattern     = up_word.pattern;
      s3_word_in.fold_4000   = fold_bytes({5'd0, up_word.elapsed[31:5]});
      s3_word_in.fold_2000   = fold_bytes({4'd0, up_word.elapsed[31:4]});
      s3_word_in.fold_1000   = fold_bytes({3'd0, up_word.elapsed[31:3]});
      s3_word_in.low_bits    = up_word.elapsed[4:0];
      s3_word_in.pulse_count = up_word.pulse_count;
      s3_word_in.pulse_rgb   = up_word.pulse_rgb;
   end

   // Phases: 4000 = 32 * 125, 2000 = 16 * 125, 1000 = 8 * 125
   assign res_4000 = reduce_res(s3_word_ff.fold_4000);
   assign res_2000 = reduce_res(s3_word_ff.fold_2000);
   assign res_1000 = reduce_res(s3_word_ff.fold_1000);

   always_comb begin
      s4_word_in.pattern     = s3_word_ff.pattern;
      s4_word_in.phase_4000  = {res_4000, s3_word_ff.low_bits};
      s4_word_in.phase_2000  = {res_2000, s3_word_ff.low_bits[3:0]};
      s4_word_in.phase_1000  = {res_1000, s3_word_ff.low_bits[2:0]};
      s4_word_in.intro_rgb   = s3_word_ff.intro_rgb;
      s4_word_in.pulse_count = s3_word_ff.pulse_count;
      s4_word_in.pulse_rgb   = s3_word_ff.pulse_rgb;
   end

   assign s3_valid_in = s3_open ? up_valid : s3_valid_ff;
   assign s4_valid_in = s4_open ? s3_valid_ff : s4_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_open) begin
         s3_word_ff <= s3_word_in;
      end
      if (s4_open) begin
         s4_word_ff <= s4_word_in;
      end
   end

   assign down_valid = s4_valid_ff;
   assign down_word  = s4_word_ff;

endmodule

`default_nettype wire

// ===== hdl/slpg_colour.sv =====
`default_nettype none

module slpg_colour (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire slpg_pkg::phase_word_type up_word,
   input  wire logic                     up_valid,
   output logic                          up_ready,
   slpg_rsp_if.source                    rsp_chan
);
   import slpg_pkg::*;

   logic    out_valid_ff, out_valid_in, out_open;
   rgb_type rgb_ff, rgb_in;
   logic    pulse_hit;

   assign out_open = !out_valid_ff || rsp_chan.ready;
   assign up_ready = out_open;

   // Pulse k is lit from 300k to 300k + 150 within the frame
   always_comb begin
      pulse_hit = 1'b0;
      for (int k = 0; k < PULSE_SLOTS; k++) begin
         if ((up_word.pulse_count > 4'(k)) &&
             (up_word.phase_4000 >= 12'(k * PULSE_PERIOD_MS)) &&
             (up_word.phase_4000 < 12'(k * PULSE_PERIOD_MS + PULSE_WIDTH_MS))) begin
            pulse_hit = 1'b1;
         end
      end
   end

   // Pick the colour for the pattern
   always_comb begin
      unique case (up_word.pattern)
         PAT_BOOT:
            rgb_in = (up_word.phase_1000 < 10'(HALF_ON_MS)) ? RGB_BLUE : RGB_OFF;
         PAT_RECOVERY:
            rgb_in = (up_word.phase_4000 < 12'(RECOVERY_ON_MS)) ? RGB_RED : RGB_OFF;
         PAT_UPDATE:
            rgb_in = (up_word.phase_1000 < 10'(HALF_ON_MS)) ? RGB_BLUE : RGB_GREEN;
         PAT_WAIT:
            rgb_in = (up_word.phase_2000 < 11'(WAIT_ON_MS)) ? RGB_BLUE : RGB_OFF;
         PAT_VERIFY:
            rgb_in = (up_word.phase_1000 < 10'(VERIFY_ON_MS)) ? RGB_BLUE : RGB_OFF;
         PAT_COMMIT:
            rgb_in = RGB_RED | RGB_BLUE;
         PAT_ERASE:
            rgb_in = (up_word.phase_1000 < 10'(HALF_ON_MS)) ? (RGB_RED | RGB_GREEN) : RGB_OFF;
         PAT_PULSE:
            rgb_in = pulse_hit ? up_word.pulse_rgb : RGB_OFF;
         PAT_INTRO:
            rgb_in = up_word.intro_rgb;
         default:
            rgb_in = RGB_OFF;
      endcase
   end

   assign out_valid_in = out_open ? up_valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_open) begin
         rgb_ff <= rgb_in;
      end
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.red_on   = rgb_ff.red;
   assign rsp_chan.green_on = rgb_ff.green;
   assign rsp_chan.blue_on  = rgb_ff.blue;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import slpg_pkg::*;

   localparam int          RESET_CYCLES    = 11;
   localparam int          SETTLE_CYCLES   = 8;
   localparam int          DRAIN_CYCLES    = 20;
   localparam int          CYCLE_LIMIT     = 300000;
   localparam int          PHASES          = 7;
   localparam int          WORDS_PER_PHASE = 220;
   localparam int          REPORT_LIMIT    = 50;
   localparam int unsigned BLINK_MS        = 1000;
   localparam int unsigned WAIT_FRAME_MS   = 2000;

   localparam logic [3:0] MODE_BAD_FIRST = 4'd12;
   localparam logic [3:0] MODE_BAD_LAST  = 4'd15;
   localparam logic [3:0] ERROR_NONE     = 4'd0;
   localparam logic [3:0] ERROR_ALL      = 4'hF;
   localparam logic [7:0] SLOT_ZERO      = 8'd0;
   localparam logic [7:0] SLOT_STRAY     = 8'd7;
   localparam logic [7:0] SLOT_FAR       = 8'd200;

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic [3:0] csr_write_data;

   slpg_req_if req_if ();
   slpg_rsp_if rsp_if ();

   status_led_pattern_generator u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Mirror of the block state
   logic [3:0]  fault_code     = ERROR_CODE_RESET;
   logic [3:0]  led_mode       = MODE_BOOT;
   logic [7:0]  led_slot       = SLOT_NONE;
   logic [3:0]  led_error      = ERROR_NONE;
   logic [31:0] mode_start_ms  = '0;
   logic [31:0] intro_start_ms = '0;
   logic [7:0]  opening_slot   = SLOT_NONE;
   logic        opening_on     = 1'b0;
   logic        opening_done   = 1'b0;

   rgb_type     expected_colours[$];
   int          mismatch_count = 0;
   int          cycle_count    = 0;
   int          burst_left     = 1;
   logic        valid_held     = 1'b0;
   logic [31:0] wall_ms        = '0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Give up on a hung run
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count == CYCLE_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic is_application(logic [3:0] mode);
      return mode == MODE_RUNNING || mode == MODE_TRIAL || mode == MODE_PROBE;
   endfunction

   function automatic rgb_type pulse_colour(logic [31:0] phase, logic [3:0] count,
                                            rgb_type colour);
      return (phase / PULSE_PERIOD_MS < count && phase % PULSE_PERIOD_MS < PULSE_WIDTH_MS)
             ? colour : RGB_OFF;
   endfunction

   // Update the mirrored mode, slot and error for one set word
   function automatic void apply_request(logic [3:0] mode, logic [7:0] slot, logic [3:0] err,
                                         logic [31:0] now);
      logic slot_ok;
      logic legal;
      logic app;
      slot_ok = slot < SLOT_APPS || slot == SLOT_NONE;
      legal   = mode <= MODE_PROBE && slot_ok && (mode != MODE_PROBE || slot == SLOT_NONE) &&
                (mode == MODE_FAULT ? (err >= ERROR_MIN && err <= ERROR_MAX)
                                    : err == ERROR_NONE);
      if (!legal) begin
         mode = MODE_FAULT;
         slot = SLOT_NONE;
         err  = fault_code;
      end
      if (mode == led_mode && slot == led_slot && err == led_error)
         return;
      mode_start_ms = now;
      led_mode      = mode;
      led_slot      = slot;
      led_error     = err;
      app           = is_application(mode);
      // The intro plays once per reset only
      if (app && (slot < SLOT_APPS || mode == MODE_PROBE) && !opening_done) begin
         intro_start_ms = now;
         opening_slot   = slot;
         opening_on     = 1'b1;
         opening_done   = 1'b1;
      end
      if (!app || slot != opening_slot)
         opening_on = 1'b0;
   endfunction

   // Work out the lit channels for one sample word
   function automatic rgb_type predict_colour(logic [31:0] now);
      logic [31:0] elapsed;
      logic [31:0] phase;
      logic [31:0] opening_ms;
      logic [3:0]  count;
      elapsed = now - mode_start_ms;
      phase   = elapsed % FRAME_MS;
      case (led_mode)
         MODE_BOOT:     return (elapsed % BLINK_MS < HALF_ON_MS) ? RGB_BLUE : RGB_OFF;
         MODE_RECOVERY: return (phase < RECOVERY_ON_MS) ? RGB_RED : RGB_OFF;
         MODE_UPDATE:   return (elapsed % BLINK_MS < HALF_ON_MS) ? RGB_BLUE : RGB_GREEN;
         MODE_WAIT:     return (elapsed % WAIT_FRAME_MS < WAIT_ON_MS) ? RGB_BLUE : RGB_OFF;
         MODE_VERIFY:   return (elapsed % BLINK_MS < VERIFY_ON_MS) ? RGB_BLUE : RGB_OFF;
         MODE_COMMIT:   return rgb_type'(RGB_RED | RGB_BLUE);
         MODE_READY:    return pulse_colour(phase, PULSES_READY, RGB_GREEN);
         MODE_ERASE: begin
            return (elapsed % BLINK_MS < HALF_ON_MS) ? rgb_type'(RGB_RED | RGB_GREEN) : RGB_OFF;
         end
         MODE_FAULT: begin
            if (led_error >= ERROR_MIN && led_error <= ERROR_MAX)
               return pulse_colour(phase, led_error, RGB_RED);
         end
         MODE_RUNNING, MODE_TRIAL, MODE_PROBE: begin
            if (led_slot < SLOT_APPS || led_slot == SLOT_NONE) begin
               if (opening_on && led_slot == opening_slot &&
                   (led_slot < SLOT_APPS || led_mode == MODE_PROBE)) begin
                  opening_ms = now - intro_start_ms;
                  if (opening_ms < INTRO_LENGTH_MS) begin
                     if (opening_ms >= INTRO_DARK_MS || opening_ms % INTRO_STEP_MS >= INTRO_LIT_MS)
                        return RGB_OFF;
                     // Slot one swaps the last two colours
                     case (opening_ms / INTRO_STEP_MS)
                        0:       return RGB_RED;
                        1:       return (led_slot == SLOT_ONE) ? RGB_BLUE : RGB_GREEN;
                        default: return (led_slot == SLOT_ONE) ? RGB_GREEN : RGB_BLUE;
                     endcase
                  end
                  opening_on = 1'b0;
               end
               if (led_mode == MODE_PROBE)
                  count = PULSES_PROBE;
               else if (led_slot < SLOT_APPS)
                  count = led_slot[3:0] + 4'd1;
               else
                  count = PULSES_NONE;
               return pulse_colour(phase, count, (led_mode == MODE_TRIAL) ? RGB_GREEN : RGB_BLUE);
            end
         end
         default: ;
      endcase
      return pulse_colour(phase, fault_code, RGB_RED);
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatch_count < REPORT_LIMIT)
         $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // Check each result word against the oldest expected colour; stall on a pattern
   always @(posedge clock) begin : rsp_check
      rgb_type want;
      static int stall_kind  = 0;
      static int stall_left  = 0;
      static int stall_phase = 0;
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_colours.size() == 0) begin
            report_mismatch($sformatf("unexpected word r%b g%b b%b",
                                      rsp_if.red_on, rsp_if.green_on, rsp_if.blue_on));
         end else begin
            want = expected_colours.pop_front();
            if (rsp_if.red_on !== want.red)
               report_mismatch($sformatf("red_on %b, want %b", rsp_if.red_on, want.red));
            if (rsp_if.green_on !== want.green)
               report_mismatch($sformatf("green_on %b, want %b", rsp_if.green_on, want.green));
            if (rsp_if.blue_on !== want.blue)
               report_mismatch($sformatf("blue_on %b, want %b", rsp_if.blue_on, want.blue));
         end
      end
      if (stall_left == 0) begin
         stall_kind = $urandom_range(0, 3);
         stall_left = $urandom_range(64, 256);
      end else begin
         stall_left--;
      end
      stall_phase++;
      case (stall_kind)
         0:       rsp_if.ready <= 1'b1;
         1:       rsp_if.ready <= ($urandom_range(0, 2) != 0);
         2:       rsp_if.ready <= (stall_phase % 16 < 11);
         default: rsp_if.ready <= (stall_phase % 32 < 12);
      endcase
   end

   // Send one word, update the mirror at acceptance, then idle between bursts
   task automatic send_word(logic op, logic [3:0] mode, logic [7:0] slot, logic [3:0] err,
                            logic [31:0] at_ms);
      req_if.valid      <= 1'b1;
      req_if.operation  <= op;
      req_if.mode_code  <= mode;
      req_if.slot       <= slot;
      req_if.error_code <= err;
      req_if.time_ms    <= at_ms;
      valid_held = 1'b1;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      if (op == OP_SAMPLE)
         expected_colours.push_back(predict_colour(at_ms));
      else
         apply_request(mode, slot, err, at_ms);
      burst_left--;
      if (burst_left == 0) begin
         req_if.valid <= 1'b0;
         valid_held = 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                  : $urandom_range(1, 12);
      end
   endtask

   task automatic sample_at(logic [31:0] at_ms);
      send_word(OP_SAMPLE, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                4'($urandom_range(0, 15)), at_ms);
   endtask

   // Drop valid, wait for every expected word and let set words clear the pipeline
   task automatic settle();
      if (valid_held) begin
         req_if.valid <= 1'b0;
         valid_held = 1'b0;
      end
      while (expected_colours.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_fault_code(logic [3:0] code);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= code;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      fault_code = code;
   endtask

   // Boot blink straight out of reset
   task automatic test_reset_state();
      sample_at(32'd499);
      sample_at(32'd500);
   endtask

   // One colour intro, kept across a same-slot change, then left one of three ways
   task automatic test_intro();
      logic [31:0] start;
      logic [3:0]  mode;
      logic [3:0]  other;
      logic [7:0]  slot;
      start = 32'd10000;
      case ($urandom_range(0, 2))
         0: begin
            mode = MODE_RUNNING;
            slot = SLOT_ZERO;
         end
         1: begin
            mode = MODE_RUNNING;
            slot = SLOT_ONE;
         end
         default: begin
            mode = MODE_PROBE;
            slot = SLOT_NONE;
         end
      endcase
      other = (mode == MODE_PROBE) ? MODE_RUNNING : MODE_TRIAL;
      send_word(OP_SET, mode, slot, ERROR_NONE, start);
      sample_at(start);
      sample_at(start + 799);
      sample_at(start + 800);
      sample_at(start + 1500);
      send_word(OP_SET, other, slot, ERROR_NONE, start + 1600);
      sample_at(start + 2100);
      sample_at(start + 2999);
      case ($urandom_range(0, 2))
         0: ;
         1: send_word(OP_SET, MODE_READY, SLOT_NONE, ERROR_NONE, start + 3500);
         default: begin
            send_word(OP_SET, other, (slot == SLOT_ONE) ? SLOT_ZERO : SLOT_ONE, ERROR_NONE,
                      start + 3500);
         end
      endcase
      send_word(OP_SET, mode, slot, ERROR_NONE, start + 3600);
      sample_at(start + 3700);
      sample_at(start + 4100);
      sample_at(start + 4200);
   endtask

   // Bad requests fall back to fault; unchanged requests keep the mode start
   task automatic test_bad_requests();
      logic [31:0] base;
      base = 32'd20000;
      send_word(OP_SET, MODE_BAD_FIRST, SLOT_NONE, ERROR_NONE, base);
      send_word(OP_SET, MODE_FAULT, SLOT_NONE, ERROR_MAX, base + 500);
      send_word(OP_SET, MODE_BOOT, SLOT_STRAY, ERROR_NONE, base + 600);
      send_word(OP_SET, MODE_PROBE, SLOT_ZERO, ERROR_NONE, base + 700);
      send_word(OP_SET, MODE_FAULT, SLOT_NONE, ERROR_NONE, base + 800);
      send_word(OP_SET, MODE_BOOT, SLOT_ONE, ERROR_MIN, base + 900);
      sample_at(base + 4301);
      send_word(OP_SET, MODE_FAULT, SLOT_NONE, ERROR_MIN, base + 5000);
      sample_at(base + 5300);
      send_word(OP_SET, MODE_BAD_LAST, SLOT_FAR, ERROR_ALL, 32'hFFFF_FF00);
      sample_at(32'hFFFF_FFFF);
      sample_at(32'h0000_0100);
   endtask

   // One random word: mostly well-formed requests and samples near pattern edges
   task automatic random_word();
      logic [3:0]  mode;
      logic [7:0]  slot;
      logic [3:0]  err;
      logic [31:0] offset;
      if ($urandom_range(0, 9) == 0)
         wall_ms = $urandom;
      else
         wall_ms = wall_ms + $urandom_range(0, 700);
      if ($urandom_range(0, 9) < 3) begin
         case ($urandom_range(0, 9))
            0: begin
               mode = led_mode;
               slot = led_slot;
               err  = led_error;
            end
            1, 2: begin
               mode = 4'($urandom_range(0, 15));
               slot = 8'($urandom_range(0, 255));
               err  = 4'($urandom_range(0, 15));
            end
            default: begin
               mode = 4'($urandom_range(MODE_BOOT, MODE_PROBE));
               case ($urandom_range(0, 2))
                  0:       slot = SLOT_ZERO;
                  1:       slot = SLOT_ONE;
                  default: slot = SLOT_NONE;
               endcase
               if (mode == MODE_PROBE)
                  slot = SLOT_NONE;
               err = (mode == MODE_FAULT) ? 4'($urandom_range(ERROR_MIN, ERROR_MAX))
                                          : ERROR_NONE;
            end
         endcase
         send_word(OP_SET, mode, slot, err, wall_ms);
      end else if ($urandom_range(0, 1) == 0) begin
         sample_at(wall_ms);
      end else begin
         // Aim at a pulse or blink boundary, one either side
         case ($urandom_range(0, 3))
            0: begin
               offset = $urandom_range(0, 13) * PULSE_PERIOD_MS +
                        $urandom_range(0, 1) * PULSE_WIDTH_MS;
            end
            1:       offset = $urandom_range(0, 3) * BLINK_MS + HALF_ON_MS;
            2:       offset = $urandom_range(0, 3) * BLINK_MS + VERIFY_ON_MS;
            default: offset = $urandom_range(0, 3) * BLINK_MS + $urandom_range(0, 1) * WAIT_ON_MS;
         endcase
         sample_at(mode_start_ms + $urandom_range(0, 2) * FRAME_MS + offset +
                   $urandom_range(0, 2) - 1);
      end
   endtask

   // Random traffic under a sweep of fault codes, the extremes among them
   task automatic test_random_traffic();
      logic [3:0] code;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       code = ERROR_NONE;
            1:       code = ERROR_ALL;
            2:       code = ERROR_MIN;
            3:       code = ERROR_MAX + 4'd1;
            4:       code = ERROR_CODE_RESET;
            default: code = 4'($urandom_range(0, 15));
         endcase
         write_fault_code(code);
         wall_ms = $urandom;
         repeat (WORDS_PER_PHASE) random_word();
      end
   endtask

   initial begin
      reset             <= 1'b1;
      csr_write_enable  <= 1'b0;
      csr_write_data    <= '0;
      req_if.valid      <= 1'b0;
      req_if.operation  <= OP_SET;
      req_if.mode_code  <= MODE_BOOT;
      req_if.slot       <= SLOT_NONE;
      req_if.error_code <= ERROR_NONE;
      req_if.time_ms    <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_intro();
      test_bad_requests();
      test_random_traffic();
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
